### rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the pointer rebound corrector.
// ----------------------------------------------------------------------------
package prc_pkg;

    typedef enum logic [1:0] {
        OP_MOTION = 2'd0,
        OP_TICK   = 2'd1,
        OP_EVENT  = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MOTION  = 3'd0,
        ST_IDLE    = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_CORRECT = 3'd3,
        ST_FOREIGN = 3'd4,
        ST_RESET   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_ARM_WINDOW = 3'd0,
        CFG_MIN_PRIOR  = 3'd1,
        CFG_SHORT_WIN  = 3'd2,
        CFG_SMALL      = 3'd3,
        CFG_OVERDRIVE  = 3'd4,
        CFG_QUIET_DEF  = 3'd5,
        CFG_QUIET_MIN  = 3'd6,
        CFG_QUIET_MAX  = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [31:0] GAP_MIN_US    = 32'd3000;
    localparam logic [31:0] GAP_MAX_US    = 32'd500000;
    localparam logic [15:0] GAP_DECAY_Q16 = 16'd60293;
    localparam logic [15:0] EST_CAP       = 16'd4096;
    localparam logic [23:0] CAND_CNT_MAX  = 24'hFFFFFF;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    typedef struct packed {
        logic [1:0]  est_dir;
        logic        est_valid;
        logic [15:0] est_counts;
        logic [31:0] est_time;
        logic        cand_active;
        logic        cand_dir;
        logic [31:0] cand_delta;
        logic [23:0] cand_counts;
        logic [31:0] cand_start;
        logic [31:0] cand_last;
    } t_axis;

    typedef struct packed {
        logic [20:0] arm_window;
        logic [12:0] min_prior;
        logic [20:0] short_win;
        logic [12:0] small_cnt;
        logic [7:0]  overdrive;
    } t_axis_cfg;

endpackage

### rtl/core/prc_axis.sv
// ----------------------------------------------------------------------------
// prc_axis
// Next-state logic of one axis on a motion beat, and its rebound correction.
// ----------------------------------------------------------------------------
module prc_axis (
    input  prc_pkg::t_axis     i_cur,
    input  prc_pkg::t_axis_cfg i_cfg,
    input  logic signed [15:0] i_delta,
    input  logic [31:0]        i_now,
    output prc_pkg::t_axis     o_next,
    output logic               o_rebound,
    output logic [31:0]        o_corr
);

    logic        pos;
    logic [1:0]  dir;
    logic [16:0] cnt;
    logic [1:0]  cdir;
    logic        est_fresh;
    logic [32:0] cs;
    logic [31:0] cs_sat;
    logic [24:0] cc;
    logic [23:0] cc_sat;
    logic        commit;
    logic [1:0]  ne_dir;
    logic [23:0] ne_cnt;
    logic [31:0] ne_time;
    logic        ne_fresh;
    logic [24:0] ne_sum;
    logic        do_note;
    logic        arm;
    logic signed [32:0] undo;
    logic signed [33:0] od;
    prc_pkg::t_axis nx;

    always_comb begin
        pos  = ~i_delta[15];
        dir  = pos ? prc_pkg::DIR_POS : prc_pkg::DIR_NEG;
        cnt  = pos ? {1'b0, i_delta} : 17'(-$signed({i_delta[15], i_delta}));
        cdir = i_cur.cand_dir ? prc_pkg::DIR_NEG : prc_pkg::DIR_POS;
        est_fresh = i_cur.est_valid
            && ((i_now - i_cur.est_time) <= {11'd0, i_cfg.arm_window});
        cs = {i_cur.cand_delta[31], i_cur.cand_delta}
            + {{17{i_delta[15]}}, i_delta};
        if (cs[32] != cs[31]) begin
            cs_sat = cs[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            cs_sat = cs[31:0];
        end
        cc = {1'b0, i_cur.cand_counts} + {8'd0, cnt};
        cc_sat = cc[24] ? prc_pkg::CAND_CNT_MAX : cc[23:0];
        commit = ((i_now - i_cur.cand_start) > {11'd0, i_cfg.short_win})
            || (cc_sat > {11'd0, i_cfg.small_cnt});
        arm = (i_cur.est_dir != prc_pkg::DIR_NONE) && (dir != i_cur.est_dir)
            && est_fresh && (i_cur.est_counts >= {3'd0, i_cfg.min_prior});

        nx = i_cur;
        do_note = 1'b0;
        ne_dir  = dir;
        ne_cnt  = {7'd0, cnt};
        ne_time = i_now;
        if (i_delta == 16'sd0) begin
            nx = i_cur;
        end else if (i_cur.cand_active) begin
            if (dir == cdir) begin
                nx.cand_delta  = cs_sat;
                nx.cand_counts = cc_sat;
                nx.cand_last   = i_now;
                if (commit) begin
                    do_note = 1'b1;
                    ne_dir  = cdir;
                    ne_cnt  = cc_sat;
                end
            end else begin
                do_note = 1'b1;
            end
            if (do_note) begin
                nx.cand_active = 1'b0;
                nx.cand_dir    = 1'b0;
                nx.cand_delta  = '0;
                nx.cand_counts = '0;
                nx.cand_start  = '0;
                nx.cand_last   = '0;
            end
        end else if (arm) begin
            nx.cand_active = 1'b1;
            nx.cand_dir    = ~pos;
            nx.cand_delta  = 32'($signed(i_delta));
            nx.cand_counts = {7'd0, cnt};
            nx.cand_start  = i_now;
            nx.cand_last   = i_now;
        end else begin
            do_note = 1'b1;
        end

        ne_fresh = (i_cur.est_dir == ne_dir) && est_fresh;
        ne_sum = {9'd0, i_cur.est_counts} + {1'b0, ne_cnt};
        if (do_note) begin
            if (ne_fresh) begin
                nx.est_counts = (ne_sum > {9'd0, prc_pkg::EST_CAP})
                    ? prc_pkg::EST_CAP : ne_sum[15:0];
            end else begin
                nx.est_dir    = ne_dir;
                nx.est_counts = (ne_cnt > 24'hFFFF) ? 16'hFFFF : ne_cnt[15:0];
            end
            nx.est_valid = 1'b1;
            nx.est_time  = ne_time;
        end
        o_next = nx;

        o_rebound = i_cur.cand_active
            && ((i_cur.cand_last - i_cur.cand_start) <= {11'd0, i_cfg.short_win})
            && (i_cur.cand_counts <= {11'd0, i_cfg.small_cnt});
        if (i_cur.cand_delta == 32'h8000_0000) begin
            undo = 33'sh0_7FFF_FFFF;
        end else begin
            undo = -$signed({i_cur.cand_delta[31], i_cur.cand_delta});
        end
        if (undo > 0) begin
            od = {undo[32], undo} + $signed({26'd0, i_cfg.overdrive});
            o_corr = (od > 34'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF : od[31:0];
        end else begin
            od = {undo[32], undo} - $signed({26'd0, i_cfg.overdrive});
            o_corr = (od < -34'sh0_8000_0000) ? 32'h8000_0000 : od[31:0];
        end
        if (i_cur.cand_delta == 32'd0) begin
            o_corr = '0;
        end
    end

endmodule

### rtl/core/pointer_rebound_corrector_unit.sv
// ----------------------------------------------------------------------------
// pointer_rebound_corrector_unit
// Per-axis rebound detection and retrospective correction for a pointing stick.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each accepted beat updates the axis state and
// its result lands in an output register the following cycle; a new beat
// is taken every cycle as long as the output register is empty or being
// drained, so throughput is one beat per clock under that condition.
module pointer_rebound_corrector_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [20:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_dx,
    input  logic signed [15:0] i_dy,
    input  logic [31:0]        i_now_us,
    input  logic               i_cursor_unmoved,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_correction_dx,
    output logic signed [31:0] o_correction_dy,
    output logic               o_deadline_valid,
    output logic [31:0]        o_deadline_us
);

    logic [20:0] r_arm, r_short, r_qdef, r_qmin, r_qmax;
    logic [12:0] r_prior, r_small;
    logic [7:0]  r_od;

    prc_pkg::t_axis r_ax [2];
    prc_pkg::t_axis n_ax [2];
    prc_pkg::t_axis mv   [2];
    logic [31:0] r_last, n_last;
    logic        r_have, n_have;
    logic [18:0] r_gap, n_gap;

    logic [2:0]  n_status;
    logic [31:0] n_cx, n_cy, n_dl;
    logic        n_dv;
    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [31:0] r_cx, r_cy, r_dl;
    logic        r_dv;

    prc_pkg::t_axis_cfg acfg;
    logic [1:0]  reb;
    logic [31:0] corr [2];
    logic        accept;
    logic [31:0] gap;
    logic [34:0] gap_dec;
    logic [20:0] qcur, qnew;
    logic        tick_due;

    assign acfg = '{arm_window: r_arm, min_prior: r_prior, short_win: r_short,
                    small_cnt: r_small, overdrive: r_od};
    assign o_ready = ~r_ovalid | i_ready;
    assign accept  = i_valid & o_ready;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        prc_axis u_axis (
            .i_cur     (r_ax[a]),
            .i_cfg     (acfg),
            .i_delta   (a == 0 ? i_dx : i_dy),
            .i_now     (i_now_us),
            .o_next    (mv[a]),
            .o_rebound (reb[a]),
            .o_corr    (corr[a])
        );
    end

    function automatic logic [20:0] quiet(input logic [18:0] g, input logic [20:0] qd,
                                         input logic [20:0] qmn, input logic [20:0] qmx);
        logic [21:0] q;
        q = (g != '0) ? 22'(({3'd0, g} * 22'd7) >> 2) : {1'b0, qd};
        if (q < {1'b0, qmn}) q = {1'b0, qmn};
        if (q > {1'b0, qmx}) q = {1'b0, qmx};
        return q[20:0];
    endfunction

    always_comb begin
        n_ax     = r_ax;
        n_last   = r_last;
        n_have   = r_have;
        n_gap    = r_gap;
        n_status = prc_pkg::ST_IDLE;
        n_cx     = '0;
        n_cy     = '0;
        gap      = i_now_us - r_last;
        gap_dec  = {16'd0, r_gap} * {19'd0, prc_pkg::GAP_DECAY_Q16};
        qcur = quiet(r_gap, r_qdef, r_qmin, r_qmax);
        tick_due = (r_ax[0].cand_active | r_ax[1].cand_active) && r_have
            && ((i_now_us - r_last) >= {11'd0, qcur});
        case (i_op)
            prc_pkg::OP_MOTION: begin
                n_status = prc_pkg::ST_MOTION;
                if (i_dx != 16'sd0 || i_dy != 16'sd0) begin
                    if (r_have && gap >= prc_pkg::GAP_MIN_US
                        && gap <= prc_pkg::GAP_MAX_US) begin
                        if (r_gap == '0 || gap > {13'd0, r_gap}) begin
                            n_gap = gap[18:0];
                        end else begin
                            n_gap = gap_dec[34:16];
                        end
                    end
                    n_last = i_now_us;
                    n_have = 1'b1;
                    n_ax   = mv;
                end
            end
            prc_pkg::OP_TICK: begin
                if (tick_due) begin
                    n_ax[0] = '0;
                    n_ax[1] = '0;
                    n_last  = '0;
                    n_have  = 1'b0;
                    if (!i_cursor_unmoved) begin
                        n_gap    = '0;
                        n_status = prc_pkg::ST_FOREIGN;
                    end else begin
                        n_cx = reb[0] ? corr[0] : '0;
                        n_cy = reb[1] ? corr[1] : '0;
                        n_status = (n_cx != '0 || n_cy != '0)
                            ? prc_pkg::ST_CORRECT : prc_pkg::ST_CLOSED;
                    end
                end
            end
            default: begin
                n_ax[0]  = '0;
                n_ax[1]  = '0;
                n_last   = '0;
                n_have   = 1'b0;
                n_gap    = '0;
                n_status = prc_pkg::ST_RESET;
            end
        endcase
        qnew = quiet(n_gap, r_qdef, r_qmin, r_qmax);
        n_dv = (n_ax[0].cand_active | n_ax[1].cand_active) && n_have;
        n_dl = n_dv ? n_last + {11'd0, qnew} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm <= 21'd400000; r_prior <= 13'd6; r_short <= 21'd120000;
            r_small <= 13'd6; r_od <= 8'd2; r_qdef <= 21'd140000;
            r_qmin <= 21'd100000; r_qmax <= 21'd700000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prc_pkg::CFG_ARM_WINDOW: r_arm   <= i_cfg_data;
                prc_pkg::CFG_MIN_PRIOR:  r_prior <= i_cfg_data[12:0];
                prc_pkg::CFG_SHORT_WIN:  r_short <= i_cfg_data;
                prc_pkg::CFG_SMALL:      r_small <= i_cfg_data[12:0];
                prc_pkg::CFG_OVERDRIVE:  r_od    <= i_cfg_data[7:0];
                prc_pkg::CFG_QUIET_DEF:  r_qdef  <= i_cfg_data;
                prc_pkg::CFG_QUIET_MIN:  r_qmin  <= i_cfg_data;
                default:                 r_qmax  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax[0] <= '0;
            r_ax[1] <= '0;
            r_last  <= '0;
            r_have  <= 1'b0;
            r_gap   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_ax   <= n_ax;
                r_last <= n_last;
                r_have <= n_have;
                r_gap  <= n_gap;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_dv <= n_dv;
            r_dl <= n_dl;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_correction_dx  = r_cx;
    assign o_correction_dy  = r_cy;
    assign o_deadline_valid = r_dv;
    assign o_deadline_us    = r_dl;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_status))
        else $error("result beat dropped while stalled");
    a_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_dv |-> r_dl == '0)
        else $error("deadline set without valid");
    a_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_status != prc_pkg::ST_CORRECT |-> r_cx == '0 && r_cy == '0)
        else $error("correction outside correction status");
    a_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> !(r_dv && r_ovalid && $past(accept)))
        else $error("deadline without motion time");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pointer rebound corrector: directed and random
// motion/tick/event beats, random idling on both sides, scoreboard checking.
// ----------------------------------------------------------------------------
typedef struct {
    logic [2:0]         status;
    logic signed [31:0] cdx;
    logic signed [31:0] cdy;
    logic               dvalid;
    logic [31:0]        deadline;
} t_result;

class rebound_scoreboard;
    t_result     pending[$];
    int          errors;
    logic [31:0] arm_window, min_prior, short_win, small_cnt, overdrive;
    logic [31:0] quiet_def, quiet_min, quiet_max;
    logic [1:0]  est_dir[2];
    bit          est_valid[2];
    logic [31:0] est_counts[2], est_time[2];
    bit          cand_active[2], cand_dir[2];
    logic signed [31:0] cand_delta[2];
    logic [31:0] cand_counts[2], cand_start[2], cand_last[2];
    logic [31:0] last_time, recent_gap;
    bit          have_last;

    function new();
        errors = 0;
        arm_window = 400000; min_prior = 6; short_win = 120000; small_cnt = 6;
        overdrive = 2; quiet_def = 140000; quiet_min = 100000; quiet_max = 700000;
        clear_all();
    endfunction

    function void set_reg(prc_pkg::t_cfg_idx idx, logic [20:0] v);
        case (idx)
            prc_pkg::CFG_ARM_WINDOW: arm_window = {11'd0, v};
            prc_pkg::CFG_MIN_PRIOR:  min_prior = {19'd0, v[12:0]};
            prc_pkg::CFG_SHORT_WIN:  short_win = {11'd0, v};
            prc_pkg::CFG_SMALL:      small_cnt = {19'd0, v[12:0]};
            prc_pkg::CFG_OVERDRIVE:  overdrive = {24'd0, v[7:0]};
            prc_pkg::CFG_QUIET_DEF:  quiet_def = {11'd0, v};
            prc_pkg::CFG_QUIET_MIN:  quiet_min = {11'd0, v};
            default:                 quiet_max = {11'd0, v};
        endcase
    endfunction

    function void clear_cand(int a);
        cand_active[a] = 0; cand_dir[a] = 0; cand_delta[a] = 0;
        cand_counts[a] = 0; cand_start[a] = 0; cand_last[a] = 0;
    endfunction

    function void wipe_axis(int a);
        est_dir[a] = prc_pkg::DIR_NONE; est_valid[a] = 0; est_counts[a] = 0;
        est_time[a] = 0;
        clear_cand(a);
    endfunction

    function void clear_all();
        wipe_axis(0); wipe_axis(1);
        last_time = 0; have_last = 0; recent_gap = 0;
    endfunction

    function logic [31:0] quiet();
        logic [31:0] q;
        q = quiet_def;
        if (recent_gap != 0) q = (recent_gap * 7) >> 2;
        if (q < quiet_min) q = quiet_min;
        if (q > quiet_max) q = quiet_max;
        return q;
    endfunction

    function void extend_est(int a, logic [1:0] dir, logic [31:0] cnt, logic [31:0] now);
        logic [31:0] s;
        if (est_dir[a] == dir && est_valid[a] && (now - est_time[a]) <= arm_window) begin
            s = est_counts[a] + cnt;
            est_counts[a] = (s > 4096) ? 4096 : s;
        end else begin
            est_dir[a] = dir;
            est_counts[a] = (cnt > 32'hFFFF) ? 32'hFFFF : cnt;
        end
        est_valid[a] = 1;
        est_time[a] = now;
    endfunction

    function void track_axis(int a, logic signed [31:0] d, logic [31:0] now);
        logic [1:0]  dir, cdir;
        logic [31:0] cnt, c, cc;
        longint      s;
        if (d == 0) return;
        dir = (d > 0) ? prc_pkg::DIR_POS : prc_pkg::DIR_NEG;
        cnt = (d > 0) ? d : -d;
        if (cand_active[a]) begin
            cdir = cand_dir[a] ? prc_pkg::DIR_NEG : prc_pkg::DIR_POS;
            if (dir == cdir) begin
                s = longint'(cand_delta[a]) + longint'(d);
                if (s > 64'sd2147483647) s = 64'sd2147483647;
                if (s < -64'sd2147483648) s = -64'sd2147483648;
                cand_delta[a] = s[31:0];
                c = cand_counts[a] + cnt;
                cand_counts[a] = (c > 32'hFFFFFF) ? 32'hFFFFFF : c;
                cand_last[a] = now;
                if ((cand_last[a] - cand_start[a]) > short_win ||
                    cand_counts[a] > small_cnt) begin
                    cc = cand_counts[a];
                    clear_cand(a);
                    extend_est(a, cdir, cc, now);
                end
                return;
            end
            clear_cand(a);
            extend_est(a, dir, cnt, now);
            return;
        end
        if (est_dir[a] != prc_pkg::DIR_NONE && dir != est_dir[a] && est_valid[a] &&
            (now - est_time[a]) <= arm_window && est_counts[a] >= min_prior) begin
            cand_active[a] = 1; cand_dir[a] = (dir == prc_pkg::DIR_NEG);
            cand_delta[a] = d; cand_counts[a] = cnt;
            cand_start[a] = now; cand_last[a] = now;
            return;
        end
        extend_est(a, dir, cnt, now);
    endfunction

    function logic signed [31:0] undo_of(logic signed [31:0] d);
        longint u;
        if (d == 0) return 0;
        u = (d == 32'sh80000000) ? 64'sd2147483647 : -longint'(d);
        if (u > 0) begin
            u += overdrive;
            if (u > 64'sd2147483647) u = 64'sd2147483647;
        end else begin
            u -= overdrive;
            if (u < -64'sd2147483648) u = -64'sd2147483648;
        end
        return u[31:0];
    endfunction

    function bit rebound(int a);
        return cand_active[a] && (cand_last[a] - cand_start[a]) <= short_win &&
               cand_counts[a] <= small_cnt;
    endfunction

    function void note_input(prc_pkg::t_op op, logic signed [15:0] dx,
                             logic signed [15:0] dy, logic [31:0] now, bit unmoved);
        t_result     r;
        logic [31:0] gap;
        r.status = prc_pkg::ST_MOTION; r.cdx = 0; r.cdy = 0;
        if (op == prc_pkg::OP_MOTION) begin
            if (dx != 0 || dy != 0) begin
                if (have_last) begin
                    gap = now - last_time;
                    if (gap >= 3000 && gap <= 500000) begin
                        if (recent_gap == 0 || gap > recent_gap) recent_gap = gap;
                        else recent_gap = 32'((64'(recent_gap) * 60293) >> 16);
                    end
                end
                last_time = now; have_last = 1;
                track_axis(0, dx, now);
                track_axis(1, dy, now);
            end
        end else if (op == prc_pkg::OP_TICK) begin
            r.status = prc_pkg::ST_IDLE;
            if ((cand_active[0] || cand_active[1]) && have_last &&
                (now - last_time) >= quiet()) begin
                if (!unmoved) begin
                    clear_all();
                    r.status = prc_pkg::ST_FOREIGN;
                end else begin
                    if (rebound(0)) r.cdx = undo_of(cand_delta[0]);
                    if (rebound(1)) r.cdy = undo_of(cand_delta[1]);
                    wipe_axis(0); wipe_axis(1);
                    have_last = 0; last_time = 0;
                    r.status = (r.cdx != 0 || r.cdy != 0) ? prc_pkg::ST_CORRECT
                                                          : prc_pkg::ST_CLOSED;
                end
            end
        end else begin
            clear_all();
            r.status = prc_pkg::ST_RESET;
        end
        r.dvalid = (cand_active[0] || cand_active[1]) && have_last;
        r.deadline = r.dvalid ? last_time + quiet() : 0;
        pending.push_back(r);
    endfunction

    task report(string msg);
        $display("MISMATCH %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(t_result got);
        t_result e;
        if (pending.size() == 0) begin
            report("beat with nothing expected");
            return;
        end
        e = pending.pop_front();
        if (got.status !== e.status)
            report($sformatf("status %0d exp %0d", got.status, e.status));
        if (got.cdx !== e.cdx) report($sformatf("cdx %0d exp %0d", got.cdx, e.cdx));
        if (got.cdy !== e.cdy) report($sformatf("cdy %0d exp %0d", got.cdy, e.cdy));
        if (got.dvalid !== e.dvalid)
            report($sformatf("dvalid %0d exp %0d", got.dvalid, e.dvalid));
        if (got.deadline !== e.deadline)
            report($sformatf("deadline %0d exp %0d", got.deadline, e.deadline));
    endtask
endclass

module tb;
    logic               i_clk = 0, i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_idx = 0;
    logic [20:0]        i_cfg_data = 0;
    logic               i_valid = 0, i_ready = 0;
    logic               o_ready, o_valid;
    logic [1:0]         i_op = 0;
    logic signed [15:0] i_dx = 0, i_dy = 0;
    logic [31:0]        i_now_us = 0;
    logic               i_cursor_unmoved = 0;
    logic [2:0]         o_status;
    logic signed [31:0] o_correction_dx, o_correction_dy;
    logic               o_deadline_valid;
    logic [31:0]        o_deadline_us;

    rebound_scoreboard sb;
    logic [31:0] clock_us;
    int          hold_cycles;
    bit          sink_busy_mode;

    pointer_rebound_corrector_unit u_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic write_reg(prc_pkg::t_cfg_idx idx, logic [20:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_beat(prc_pkg::t_op op, logic signed [15:0] dx,
                             logic signed [15:0] dy, logic [31:0] now, bit unmoved,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_dx <= dx; i_dy <= dy;
        i_now_us <= now; i_cursor_unmoved <= unmoved;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, dx, dy, now, unmoved);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // small motion mostly, sometimes extreme
    function automatic logic signed [15:0] pick_delta(bit sign);
        logic signed [15:0] d;
        case ($urandom_range(0, 9))
            0: d = 0;
            1: d = 16'sh8000;
            2: d = 16'sh7FFF;
            3: d = 16'($urandom);
            default: d = 16'($urandom_range(1, 4));
        endcase
        if (sign && $urandom_range(0, 9) > 1 && d > 0) d = -d;
        return d;
    endfunction

    task automatic episode();
        int          n;
        bit          neg;
        logic [31:0] step;
        neg = $urandom_range(0, 1);
        step = $urandom_range(0, 3) == 0 ? $urandom_range(0, 600000) :
               $urandom_range(2000, 30000);
        n = $urandom_range(2, 6);
        repeat (n) begin
            clock_us += step;
            send_beat(prc_pkg::OP_MOTION, neg ? -16'sd3 : 16'sd3,
                      $urandom_range(0, 3) == 0 ? pick_delta($urandom_range(0, 1)) : 16'sd2,
                      clock_us, 0, 0);
        end
        repeat ($urandom_range(1, 3)) begin
            clock_us += step;
            send_beat(prc_pkg::OP_MOTION, $urandom_range(0, 5) == 0 ? pick_delta(neg) :
                      16'((neg ? 16'sd1 : -16'sd1) * $urandom_range(1, 3)),
                      $urandom_range(0, 2) == 0 ? -16'sd2 : 16'sd0, clock_us, 0, 0);
        end
        repeat ($urandom_range(1, 3)) begin
            clock_us += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 800000);
            send_beat(prc_pkg::OP_TICK, 0, 0, clock_us, $urandom_range(0, 7) != 0, 0);
        end
    endtask

    task automatic noise();
        prc_pkg::t_op op;
        op = prc_pkg::t_op'($urandom_range(0, 9) == 0 ? $urandom_range(2, 3) :
                            $urandom_range(0, 1));
        clock_us += $urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 200000);
        send_beat(op, pick_delta($urandom_range(0, 1)), pick_delta($urandom_range(0, 1)),
                  clock_us, $urandom_range(0, 1), 0);
    endtask

    task automatic random_cfg(int mode);
        if (mode == 0) begin
            write_reg(prc_pkg::CFG_ARM_WINDOW, 21'd400000);
            write_reg(prc_pkg::CFG_MIN_PRIOR, 21'd6);
            write_reg(prc_pkg::CFG_SHORT_WIN, 21'd120000);
            write_reg(prc_pkg::CFG_SMALL, 21'd6);
            write_reg(prc_pkg::CFG_OVERDRIVE, 21'd2);
            write_reg(prc_pkg::CFG_QUIET_DEF, 21'd140000);
            write_reg(prc_pkg::CFG_QUIET_MIN, 21'd100000);
            write_reg(prc_pkg::CFG_QUIET_MAX, 21'd700000);
        end else if (mode == 1) begin
            write_reg(prc_pkg::CFG_ARM_WINDOW, 21'd2000000);
            write_reg(prc_pkg::CFG_MIN_PRIOR, 21'd0);
            write_reg(prc_pkg::CFG_SHORT_WIN, 21'd2000000);
            write_reg(prc_pkg::CFG_SMALL, 21'd4096);
            write_reg(prc_pkg::CFG_OVERDRIVE, 21'd255);
            write_reg(prc_pkg::CFG_QUIET_DEF, 21'd0);
            write_reg(prc_pkg::CFG_QUIET_MIN, 21'd0);
            write_reg(prc_pkg::CFG_QUIET_MAX, 21'd2000000);
        end else if (mode == 2) begin
            write_reg(prc_pkg::CFG_ARM_WINDOW, 21'd0);
            write_reg(prc_pkg::CFG_MIN_PRIOR, 21'd4096);
            write_reg(prc_pkg::CFG_SHORT_WIN, 21'd0);
            write_reg(prc_pkg::CFG_SMALL, 21'd0);
            write_reg(prc_pkg::CFG_OVERDRIVE, 21'd0);
            write_reg(prc_pkg::CFG_QUIET_DEF, 21'd2000000);
            write_reg(prc_pkg::CFG_QUIET_MIN, 21'd2000000);
            write_reg(prc_pkg::CFG_QUIET_MAX, 21'd0);
        end else begin
            write_reg(prc_pkg::CFG_ARM_WINDOW, 21'($urandom_range(0, 2000000)));
            write_reg(prc_pkg::CFG_MIN_PRIOR, 21'($urandom_range(0, 12)));
            write_reg(prc_pkg::CFG_SHORT_WIN, 21'($urandom_range(0, 300000)));
            write_reg(prc_pkg::CFG_SMALL, 21'($urandom_range(0, 20)));
            write_reg(prc_pkg::CFG_OVERDRIVE, 21'($urandom_range(0, 255)));
            write_reg(prc_pkg::CFG_QUIET_DEF, 21'($urandom_range(0, 2000000)));
            write_reg(prc_pkg::CFG_QUIET_MIN, 21'($urandom_range(0, 200000)));
            write_reg(prc_pkg::CFG_QUIET_MAX, 21'($urandom_range(0, 2000000)));
        end
    endtask

    // receiver: random stall per beat in busy mode, plus one long hold-off
    initial begin
        t_result r;
        int      wait_n;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            wait_n = sink_busy_mode ? $urandom_range(0, 14) : 0;
            if (hold_cycles > 0) begin
                wait_n += hold_cycles;
                hold_cycles = 0;
            end
            if (wait_n > 0) begin
                i_ready <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1;
            do begin
                @(posedge i_clk);
                if (o_valid) begin
                    r.status = o_status; r.cdx = o_correction_dx;
                    r.cdy = o_correction_dy; r.dvalid = o_deadline_valid;
                    r.deadline = o_deadline_us;
                    sb.check_result(r);
                end
            end while (!o_valid);
        end
    end

    initial begin
        sb = new();
        clock_us = 1000;
        hold_cycles = 0;
        sink_busy_mode = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: default settings, rebound and corrections
        repeat (3) begin
            clock_us += 10000;
            send_beat(prc_pkg::OP_MOTION, 16'sd4, 16'sd0, clock_us, 0, 0);
        end
        clock_us += 10000; send_beat(prc_pkg::OP_MOTION, -16'sd2, 16'sd0, clock_us, 0, 0);
        clock_us += 10000; send_beat(prc_pkg::OP_MOTION, 16'sd0, 16'sd0, clock_us, 0, 0);
        clock_us += 500000; send_beat(prc_pkg::OP_TICK, 0, 0, clock_us, 1, 0);
        send_beat(prc_pkg::OP_SPARE, 0, 0, clock_us, 0, 0);
        send_beat(prc_pkg::OP_EVENT, 0, 0, clock_us, 1, 0);
        drain();
        random_cfg(1);
        clock_us = 32'hFFFF_0000;
        send_beat(prc_pkg::OP_MOTION, 16'sh7FFF, 16'sh8000, clock_us, 0, 0);
        clock_us += 5000;
        send_beat(prc_pkg::OP_MOTION, 16'sh8000, 16'sh7FFF, clock_us, 0, 0);
        clock_us += 5000;
        send_beat(prc_pkg::OP_MOTION, 16'sh8000, 16'sh7FFF, clock_us, 0, 0);
        send_beat(prc_pkg::OP_MOTION, 16'sh8000, 16'sh7FFF, clock_us, 0, 0);
        send_beat(prc_pkg::OP_TICK, 0, 0, clock_us - 1, 1, 0);
        clock_us += 1000000; send_beat(prc_pkg::OP_TICK, 0, 0, clock_us, 1, 0);
        send_beat(prc_pkg::OP_MOTION, 16'sd5, -16'sd5, clock_us, 1, 0);
        clock_us += 3000; send_beat(prc_pkg::OP_MOTION, -16'sd1, 16'sd1, clock_us, 1, 0);
        clock_us += 2000000; send_beat(prc_pkg::OP_TICK, 0, 0, clock_us, 0, 0);
        drain();

        // long receiver hold-off while the sender keeps offering beats
        hold_cycles = 200;
        repeat (40) noise();
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            random_cfg(phase % 4);
            sink_busy_mode = (phase % 3) != 2;
            for (int k = 0; k < 225; ) begin
                if ($urandom_range(0, 3) != 0) begin
                    episode();
                    k += 8;
                end else begin
                    noise();
                    k += 1;
                end
            end
            send_beat(prc_pkg::OP_EVENT, 0, 0, clock_us, 0, 1);
            drain();
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
